FILE: hw/rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, constants and helpers for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int TOP_ORDER  = 12;
    localparam int IDX_W      = TOP_ORDER;
    localparam int LINK_W     = TOP_ORDER + 1;
    localparam int ORD_W      = 4;
    localparam int NUM_BLOCKS = 1 << TOP_ORDER;
    localparam int BLK_SHIFT  = 3;
    localparam int ENTRY_W    = ORD_W + 2 + 2 * LINK_W;

    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(NUM_BLOCKS);
    localparam logic [ORD_W-1:0]  TOP_ORD  = ORD_W'(TOP_ORDER);

    localparam logic       OP_ALLOC = 1'b0;
    localparam logic       OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_BLOCK = 2'd1;
    localparam logic [1:0] ST_TOO_BIG  = 2'd2;
    localparam logic [1:0] ST_BAD_FREE = 2'd3;

    typedef struct packed {
        logic        opcode;
        logic [15:0] request_bytes;
        logic [15:0] free_offset;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [14:0] granted_offset;
        logic [3:0]  granted_order;
    } rsp_t;

    typedef struct packed {
        logic [ORD_W-1:0]  blk_order;
        logic              is_free;
        logic              is_alloc;
        logic [LINK_W-1:0] next_link;
        logic [LINK_W-1:0] prev_link;
    } entry_t;

    // order needed for a byte count; TOP_ORDER + 1 means too large
    function automatic logic [ORD_W-1:0] calc_want(input logic [15:0] bytes);
        logic [16:0] nblk;
        logic [12:0] m;
        logic [ORD_W-1:0] w;
        nblk = (17'(bytes) + 17'd7) >> BLK_SHIFT;
        m    = (nblk == 17'd0) ? 13'd0 : 13'(nblk - 17'd1);
        w    = '0;
        for (int i = 0; i < 13; i++) begin
            if (m[i])
            begin
                w = ORD_W'(i + 1);
            end
        end
        return w;
    endfunction

endpackage

FILE: hw/rtl/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/buddy_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator_unit
// Binary buddy allocator over 4096 blocks of 8 bytes, orders 0 to 12.
// Block entries and free-list links live in one RAM; list heads in flops.
//
//  channel | valid     | stall     | word
//  --------+-----------+-----------+------------------------------
//  request | req_valid | req_stall | req (opcode, bytes, offset)
//  result  | rsp_valid | rsp_stall | rsp (status, offset, order)
//
// After reset a clearing pass writes all 4096 RAM entries; requests
// stall until it ends. One request is worked at a time. Allocate: head
// read, unlink, one split step per order, plus a link update when the
// taken block has a successor on its list; free: read and check, then a
// buddy read and unlink per merge. Each read-modify-write of a list link
// uses the single RAM read port. A held result stalls only the final handoff.
// ----------------------------------------------------------------------------
module buddy_block_allocator_unit
    import bba_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_AHEAD = 4'd2;
    localparam logic [3:0] S_AUNL  = 4'd3;
    localparam logic [3:0] S_SPLIT = 4'd4;
    localparam logic [3:0] S_FRD   = 4'd5;
    localparam logic [3:0] S_FCHK  = 4'd6;
    localparam logic [3:0] S_FLOOP = 4'd7;
    localparam logic [3:0] S_FBUD  = 4'd8;
    localparam logic [3:0] S_FUNN  = 4'd9;
    localparam logic [3:0] S_FMRG  = 4'd10;
    localparam logic [3:0] S_FPUSH = 4'd11;
    localparam logic [3:0] S_LRD   = 4'd12;
    localparam logic [3:0] S_LWR   = 4'd13;
    localparam logic [3:0] S_DONE  = 4'd14;

    logic [3:0]        state_reg, state_next;
    logic [IDX_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [ORD_W-1:0]  want_reg, want_next;
    logic [ORD_W-1:0]  ord_reg, ord_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  bud_reg, bud_next;
    entry_t            cur_reg, cur_next;
    entry_t            bent_reg, bent_next;
    logic [IDX_W-1:0]  lnk_addr_reg, lnk_addr_next;
    logic [LINK_W-1:0] lnk_val_reg, lnk_val_next;
    logic              lnk_sel_reg, lnk_sel_next;
    logic [3:0]        lnk_ret_reg, lnk_ret_next;
    rsp_t              res_reg, res_next;
    logic [LINK_W-1:0] head_reg [TOP_ORDER+1];
    logic [LINK_W-1:0] head_next [TOP_ORDER+1];
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    entry_t            ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    entry_t            ram_rdata;
    logic [ENTRY_W-1:0] ram_rword;

    bba_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_BLOCKS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rword)
    );

    assign ram_rdata = entry_t'(ram_rword);

    logic out_load;
    assign out_load = (state_reg == S_DONE) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        logic [ORD_W-1:0]  w;
        logic [ORD_W-1:0]  found;
        logic              hit;
        logic [ORD_W-1:0]  o1;
        logic [IDX_W-1:0]  bud;
        logic [LINK_W-1:0] h;
        entry_t            e;

        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        want_next     = want_reg;
        ord_next      = ord_reg;
        idx_next      = idx_reg;
        bud_next      = bud_reg;
        cur_next      = cur_reg;
        bent_next     = bent_reg;
        lnk_addr_next = lnk_addr_reg;
        lnk_val_next  = lnk_val_reg;
        lnk_sel_next  = lnk_sel_reg;
        lnk_ret_next  = lnk_ret_reg;
        res_next      = res_reg;
        head_next     = head_reg;
        ram_we        = 1'b0;
        ram_waddr     = idx_reg;
        ram_wdata     = '0;
        ram_raddr     = idx_reg;
        req_stall     = (state_reg != S_IDLE);
        w     = '0;
        found = '0;
        hit   = 1'b0;
        o1    = '0;
        bud   = '0;
        h     = '0;
        e     = '0;

        unique case (state_reg)
            S_CLR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                if (clr_cnt_reg == '0)
                begin
                    ram_wdata = '{blk_order: TOP_ORD, is_free: 1'b1, is_alloc: 1'b0,
                                  next_link: NIL_LINK, prev_link: NIL_LINK};
                end
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IDX_W'(NUM_BLOCKS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                res_next = '0;
                if (req_valid)
                begin
                    if (req.opcode == OP_ALLOC)
                    begin
                        w = calc_want(req.request_bytes);
                        want_next = w;
                        for (int i = TOP_ORDER; i >= 0; i--)
                        begin
                            if (!head_reg[i][LINK_W-1] && i >= int'(w))
                            begin
                                found = ORD_W'(i);
                                hit   = 1'b1;
                            end
                        end
                        if (w > TOP_ORD)
                        begin
                            res_next.status = ST_TOO_BIG;
                            state_next = S_DONE;
                        end
                        else if (!hit)
                        begin
                            res_next.status = ST_NO_BLOCK;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            ord_next   = found;
                            idx_next   = head_reg[found][IDX_W-1:0];
                            state_next = S_AHEAD;
                        end
                    end
                    else
                    begin
                        idx_next = req.free_offset[BLK_SHIFT+IDX_W-1:BLK_SHIFT];
                        if (req.free_offset[BLK_SHIFT-1:0] != '0 || req.free_offset[15])
                        begin
                            res_next.status = ST_BAD_FREE;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_FRD;
                        end
                    end
                end
            end
            S_AHEAD:
            begin
                ram_raddr  = idx_reg;
                state_next = S_AUNL;
            end
            S_AUNL:
            begin
                // the taken block is the list head: its prev is already none
                cur_next = ram_rdata;
                head_next[ord_reg] = ram_rdata.next_link;
                if (!ram_rdata.next_link[LINK_W-1])
                begin
                    lnk_addr_next = ram_rdata.next_link[IDX_W-1:0];
                    lnk_val_next  = NIL_LINK;
                    lnk_sel_next  = 1'b0;
                    lnk_ret_next  = S_SPLIT;
                    state_next    = S_LRD;
                end
                else
                begin
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                ram_we = 1'b1;
                if (ord_reg > want_reg)
                begin
                    o1  = ord_reg - 1'b1;
                    bud = idx_reg ^ (IDX_W'(1) << o1);
                    h   = head_reg[o1];
                    ram_waddr = bud;
                    ram_wdata = '{blk_order: o1, is_free: 1'b1, is_alloc: 1'b0,
                                  next_link: h, prev_link: NIL_LINK};
                    head_next[o1] = {1'b0, bud};
                    ord_next = o1;
                    if (!h[LINK_W-1])
                    begin
                        lnk_addr_next = h[IDX_W-1:0];
                        lnk_val_next  = {1'b0, bud};
                        lnk_sel_next  = 1'b0;
                        lnk_ret_next  = S_SPLIT;
                        state_next    = S_LRD;
                    end
                end
                else
                begin
                    ram_waddr = idx_reg;
                    ram_wdata = '{blk_order: want_reg, is_free: 1'b0, is_alloc: 1'b1,
                                  next_link: cur_reg.next_link,
                                  prev_link: cur_reg.prev_link};
                    res_next.status         = ST_OK;
                    res_next.granted_offset = {idx_reg, {BLK_SHIFT{1'b0}}};
                    res_next.granted_order  = want_reg;
                    state_next = S_DONE;
                end
            end
            S_FRD:
            begin
                ram_raddr  = idx_reg;
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                if (!ram_rdata.is_alloc || ram_rdata.blk_order > TOP_ORD)
                begin
                    res_next.status = ST_BAD_FREE;
                    state_next = S_DONE;
                end
                else
                begin
                    e = ram_rdata;
                    e.is_alloc = 1'b0;
                    ram_we    = 1'b1;
                    ram_waddr = idx_reg;
                    ram_wdata = e;
                    cur_next  = e;
                    ord_next  = ram_rdata.blk_order;
                    state_next = S_FLOOP;
                end
            end
            S_FLOOP:
            begin
                if (ord_reg < TOP_ORD)
                begin
                    bud = idx_reg ^ (IDX_W'(1) << ord_reg);
                    bud_next   = bud;
                    ram_raddr  = bud;
                    state_next = S_FBUD;
                end
                else
                begin
                    state_next = S_FPUSH;
                end
            end
            S_FBUD:
            begin
                if (!ram_rdata.is_free || ram_rdata.blk_order != ord_reg)
                begin
                    state_next = S_FPUSH;
                end
                else
                begin
                    // drop the buddy from its list
                    bent_next = ram_rdata;
                    e = ram_rdata;
                    e.is_free = 1'b0;
                    ram_we    = 1'b1;
                    ram_waddr = bud_reg;
                    ram_wdata = e;
                    if (!ram_rdata.prev_link[LINK_W-1])
                    begin
                        lnk_addr_next = ram_rdata.prev_link[IDX_W-1:0];
                        lnk_val_next  = ram_rdata.next_link;
                        lnk_sel_next  = 1'b1;
                        lnk_ret_next  = S_FUNN;
                        state_next    = S_LRD;
                    end
                    else
                    begin
                        head_next[ord_reg] = ram_rdata.next_link;
                        state_next = S_FUNN;
                    end
                end
            end
            S_FUNN:
            begin
                if (!bent_reg.next_link[LINK_W-1])
                begin
                    lnk_addr_next = bent_reg.next_link[IDX_W-1:0];
                    lnk_val_next  = bent_reg.prev_link;
                    lnk_sel_next  = 1'b0;
                    lnk_ret_next  = S_FMRG;
                    state_next    = S_LRD;
                end
                else
                begin
                    state_next = S_FMRG;
                end
            end
            S_FMRG:
            begin
                if (bud_reg < idx_reg)
                begin
                    idx_next = bud_reg;
                end
                ord_next   = ord_reg + 1'b1;
                state_next = S_FLOOP;
            end
            S_FPUSH:
            begin
                h = head_reg[ord_reg];
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = '{blk_order: ord_reg, is_free: 1'b1, is_alloc: 1'b0,
                              next_link: h, prev_link: NIL_LINK};
                head_next[ord_reg] = {1'b0, idx_reg};
                res_next.status        = ST_OK;
                res_next.granted_order = ord_reg;
                if (!h[LINK_W-1])
                begin
                    lnk_addr_next = h[IDX_W-1:0];
                    lnk_val_next  = {1'b0, idx_reg};
                    lnk_sel_next  = 1'b0;
                    lnk_ret_next  = S_DONE;
                    state_next    = S_LRD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_LRD:
            begin
                ram_raddr  = lnk_addr_reg;
                state_next = S_LWR;
            end
            S_LWR:
            begin
                e = ram_rdata;
                if (lnk_sel_reg)
                begin
                    e.next_link = lnk_val_reg;
                end
                else
                begin
                    e.prev_link = lnk_val_reg;
                end
                ram_we     = 1'b1;
                ram_waddr  = lnk_addr_reg;
                ram_wdata  = e;
                state_next = lnk_ret_reg;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // hold a stalled result, load a fresh one when the slot frees
    always_comb
    begin
        rsp_valid_next = out_load | (rsp_valid_reg & rsp_stall);
        rsp_next       = out_load ? res_reg : rsp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i <= TOP_ORDER; i++)
            begin
                head_reg[i] <= (i == TOP_ORDER) ? '0 : NIL_LINK;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            head_reg      <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        want_reg     <= want_next;
        ord_reg      <= ord_next;
        idx_reg      <= idx_next;
        bud_reg      <= bud_next;
        cur_reg      <= cur_next;
        bent_reg     <= bent_next;
        lnk_addr_reg <= lnk_addr_next;
        lnk_val_reg  <= lnk_val_next;
        lnk_sel_reg  <= lnk_sel_next;
        lnk_ret_reg  <= lnk_ret_next;
        res_reg      <= res_next;
        rsp_reg      <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef ASSERT_OFF
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |-> rsp.granted_offset == '0 && rsp.granted_order == '0)
        else $error("error result carries nonzero offset or order");

    a_order_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.granted_order <= TOP_ORD)
        else $error("granted order beyond top order");

    a_top_head: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg[TOP_ORDER] == NIL_LINK || head_reg[TOP_ORDER] == '0)
        else $error("top-order list holds a block other than block zero");

    a_load_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && rsp_valid && rsp_stall |=> state_reg == S_DONE)
        else $error("result left while output slot was held");
`endif

endmodule
